FILE: rtl/dwr_pkg.sv
// ----------------------------------------------------------------------------
// Draw without replacement package
// Shared constants and transfer types for the draw block and its remainder unit.
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int MAX_POOL = 64;
  localparam int ADDR_W   = $clog2(MAX_POOL);
  localparam int VAL_W    = 7;
  localparam int PS_W     = 7;
  localparam int WORD_W   = 31;
  localparam int CNT_W    = $clog2(WORD_W + 1);

  localparam logic [PS_W-1:0] POOL_SIZE_RST = PS_W'(35);

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_DRAW    = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] random_word;
  } dwr_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] drawn_value;
    logic             exhausted;
  } dwr_out_t;

endpackage

FILE: rtl/dwr_mod.sv
// ----------------------------------------------------------------------------
// Draw without replacement remainder unit
// Bit-serial restoring remainder of the random word by the current pool index.
// ----------------------------------------------------------------------------
module dwr_mod
  import dwr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [ADDR_W-1:0] divisor,
  output logic              done,
  output logic [ADDR_W-1:0] remainder
);

  logic [WORD_W-1:0] word_r;
  logic [ADDR_W-1:0] div_r;
  logic [ADDR_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [ADDR_W:0]   trial;
  logic [ADDR_W:0]   trial_sub;
  logic [ADDR_W-1:0] rem_nxt;

  always_comb begin
    trial     = {rem_r, word_r[WORD_W-1]};
    trial_sub = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial_sub[ADDR_W-1:0];
    end else begin
      rem_nxt = trial[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(WORD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= dividend;
      div_r  <= divisor;
      rem_r  <= '0;
    end else if (run_r) begin
      word_r <= {word_r[WORD_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/draw_without_replacement.sv
// ----------------------------------------------------------------------------
// Draw without replacement
// Partial shuffle of a pool table that hands out each value at most once.
// ----------------------------------------------------------------------------
// An input transfer is taken when start is high and busy is low. A restart
// transfer refills the pool so that entry j holds j+1 and clears the draw
// count; a draw transfer uses random_word to pick and swap one pool entry.
// Every input transfer gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so the result must be taken.
// A restart or an exhausted draw answers in the cycle after the transfer.
// A normal draw runs the 31-step bit-serial remainder unit and then a
// read-read-write-write swap on the pool memory; busy is high until the
// result is shown, and a new item can be taken in the cycle it is shown.
// pool_size is written through cfg_we and cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
// After reset pool_size is 35, the draw count is zero and the pool reads as
// freshly filled, since per-entry valid bits stand in for the refill.
// ----------------------------------------------------------------------------
module draw_without_replacement
  import dwr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dwr_in_t         in_data,
  output logic            out_valid,
  output dwr_out_t        out_data,
  input  logic            cfg_we,
  input  logic [PS_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD_K,
    S_RD_R,
    S_WR_R
  } state_t;

  state_t            state_r;
  logic [PS_W-1:0]   pool_size_r;
  logic [ADDR_W-1:0] dc_r;
  logic [ADDR_W-1:0] r_r;
  logic [ADDR_W-1:0] k_r;
  logic [VAL_W-1:0]  val_k_r;
  logic              out_valid_r;
  dwr_out_t          out_data_r;

  logic [VAL_W-1:0]  mem [MAX_POOL];
  logic [MAX_POOL-1:0] vld_r;
  logic [VAL_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [ADDR_W-1:0] rd_addr_r;

  logic              accept;
  logic [PS_W-1:0]   n_eff;
  logic              exh;
  logic [ADDR_W-1:0] r_calc;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_rem;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  rd_val;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (int'(pool_size_r) > MAX_POOL) begin
      n_eff = PS_W'(MAX_POOL);
    end else begin
      n_eff = pool_size_r;
    end
    exh       = (int'(dc_r) + 1) >= int'(n_eff);
    r_calc    = ADDR_W'(int'(n_eff) - int'(dc_r) - 1);
    div_start = accept && (in_data.mode == MODE_DRAW) && !exh;
  end

  dwr_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_data.random_word),
    .divisor   (r_calc),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign rd_val = rd_vld_r ? rd_data_r : (VAL_W'(rd_addr_r) + VAL_W'(1));

  always_comb begin
    rd_addr = r_r;
    wr_en   = 1'b0;
    wr_addr = r_r;
    wr_data = val_k_r;
    unique case (state_r)
      S_DIV: begin
        rd_addr = div_rem;
      end
      S_RD_R: begin
        wr_en   = 1'b1;
        wr_addr = k_r;
        wr_data = rd_val;
      end
      S_WR_R: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_addr = r_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (accept && (in_data.mode == MODE_RESTART)) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
    end else if (cfg_we) begin
      pool_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      r_r         <= '0;
      k_r         <= '0;
      val_k_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.mode == MODE_RESTART) begin
              dc_r        <= '0;
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
            end else if (exh) begin
              out_valid_r           <= 1'b1;
              out_data_r.drawn_value <= '0;
              out_data_r.exhausted   <= 1'b1;
            end else begin
              r_r     <= r_calc;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            k_r     <= div_rem;
            state_r <= S_RD_K;
          end
        end
        S_RD_K: begin
          val_k_r <= rd_val;
          state_r <= S_RD_R;
        end
        S_RD_R: begin
          state_r <= S_WR_R;
        end
        S_WR_R: begin
          dc_r                   <= dc_r + 1'b1;
          out_valid_r            <= 1'b1;
          out_data_r.drawn_value <= val_k_r;
          out_data_r.exhausted   <= 1'b0;
          state_r                <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A draw that can proceed must hand its work to the remainder unit.
  a_draw_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("draw did not enter the remainder phase");

  // The remainder unit only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder finished outside the remainder phase");

  // The swap always ends in exactly one result transfer.
  a_swap_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_R) |=> (out_valid && !out_data.exhausted))
    else $error("swap did not produce a result");

  // An exhausted result never carries a value.
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exhausted) |-> (out_data.drawn_value == '0))
    else $error("exhausted result carries a value");

  // The swapped index lies strictly below the top index.
  a_k_below_r: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_K) |-> (k_r < r_r))
    else $error("swap index out of range");

endmodule
